@@ src/ofrs_pkg.sv @@
// ----------------------------------------------------------------------------
// ofrs_pkg
// Shared types and constants for the oled frame buffer refresh sequencer.
// ----------------------------------------------------------------------------
package ofrs_pkg;

   localparam int DISPLAY_WIDTH_DEF  = 128;
   localparam int DISPLAY_HEIGHT_DEF = 64;
   localparam int FRAME_BYTES_DEF    = 1024;
   localparam int CHUNK_BYTES_DEF    = 16;

   localparam int DEV_ADDR_W = 7;
   localparam int DELAY_W    = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'd60;
   localparam logic [DELAY_W-1:0]    DELAY_RESET    = 10'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STARTUP_DELAY  = 1'b1;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   // pixel index fits x + 31 * 256
   localparam int PIX_IDX_W = 13;

   localparam int CMDQ_DEPTH = 2;

   localparam int INIT_LEN  = 25;
   localparam int SETUP_LEN = 6;

   localparam logic [7:0] CTRL_CMD  = 8'h00;
   localparam logic [7:0] CTRL_DATA = 8'h40;

   localparam logic [7:0] INIT_LIST [INIT_LEN] = '{
      8'hAE, 8'hD5, 8'h80, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40, 8'h8D, 8'h14,
      8'h20, 8'h00, 8'hA1, 8'hC8, 8'hDA, 8'h12, 8'h81, 8'hCF, 8'hD9, 8'hF1,
      8'hDB, 8'h40, 8'hA4, 8'hA6, 8'hAF
   };

   localparam logic [7:0] WINDOW_LIST [SETUP_LEN] = '{
      8'h21, 8'h00, 8'h7F, 8'h22, 8'h00, 8'h07
   };

   typedef enum logic [2:0] {
      OP_STEP   = 3'd0,
      OP_PIXEL  = 3'd1,
      OP_CLEAR  = 3'd2,
      OP_START  = 3'd3,
      OP_UPDATE = 3'd4,
      OP_ERROR  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      CMD_STEP,
      CMD_PIXEL,
      CMD_CLEAR,
      CMD_START,
      CMD_UPDATE,
      CMD_ERROR,
      CMD_NOP
   } cmd_kind_type;

   typedef enum logic [2:0] {
      MODE_OFF   = 3'd0,
      MODE_WAIT  = 3'd1,
      MODE_INIT  = 3'd2,
      MODE_READY = 3'd3,
      MODE_SETUP = 3'd4,
      MODE_FRAME = 3'd5,
      MODE_ERROR = 3'd6
   } mode_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_PX_WRITE,
      BK_HDR_ADDR,
      BK_HDR_CTRL,
      BK_CMD_BYTE,
      BK_FR_DATA,
      BK_STATUS
   } back_state_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic                 ms;
      logic                 link_ready;
      logic [PIX_IDX_W-1:0] pix_addr;
      logic [7:0]           pix_mask;
      logic                 pix_on;
   } cmd_type;

endpackage

@@ src/ofrs_ram.sv @@
// ----------------------------------------------------------------------------
// ofrs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ofrs_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ofrs_front.sv @@
// ----------------------------------------------------------------------------
// ofrs_front
// Takes request transactions, decodes the operation and checks pixel range.
// ----------------------------------------------------------------------------
module ofrs_front #(
   parameter int DISPLAY_WIDTH  = ofrs_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = ofrs_pkg::DISPLAY_HEIGHT_DEF,
   parameter int FRAME_BYTES    = ofrs_pkg::FRAME_BYTES_DEF
) (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ofrs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [ofrs_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                            hold,
   input  logic                            q_full,
   output logic                            q_push,
   output ofrs_pkg::cmd_type               q_cmd
);

   import ofrs_pkg::*;

   logic                 ms;
   logic                 link_ready;
   logic [7:0]           pix_x;
   logic [7:0]           pix_y;
   logic                 pix_on;
   logic [PIX_IDX_W-1:0] pix_idx;
   logic                 in_range;

   assign ms         = req_tdata[0];
   assign link_ready = req_tdata[1];
   assign pix_x      = req_tdata[9:2];
   assign pix_y      = req_tdata[17:10];
   assign pix_on     = req_tdata[18];

   assign pix_idx = PIX_IDX_W'(pix_x)
                  + PIX_IDX_W'(pix_y[7:3]) * PIX_IDX_W'(DISPLAY_WIDTH);

   assign in_range = ({1'b0, pix_x} < 9'(DISPLAY_WIDTH))
                  && ({1'b0, pix_y} < 9'(DISPLAY_HEIGHT))
                  && ({1'b0, pix_idx} < (PIX_IDX_W + 1)'(FRAME_BYTES));

   always_comb begin
      q_cmd            = '0;
      q_cmd.ms         = ms;
      q_cmd.link_ready = link_ready;
      q_cmd.pix_addr   = pix_idx;
      q_cmd.pix_mask   = 8'(8'd1 << pix_y[2:0]);
      q_cmd.pix_on     = pix_on;
      unique case (op_type'(req_tuser))
         OP_STEP:   q_cmd.kind = CMD_STEP;
         OP_PIXEL:  q_cmd.kind = in_range ? CMD_PIXEL : CMD_NOP;
         OP_CLEAR:  q_cmd.kind = CMD_CLEAR;
         OP_START:  q_cmd.kind = CMD_START;
         OP_UPDATE: q_cmd.kind = CMD_UPDATE;
         OP_ERROR:  q_cmd.kind = CMD_ERROR;
         default:   q_cmd.kind = CMD_NOP;
      endcase
   end

   assign req_tready = !q_full && !hold;
   assign q_push     = req_tvalid && req_tready;

endmodule

@@ src/ofrs_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// ofrs_cmd_fifo
// Short queue of decoded commands between the front and the back end.
// ----------------------------------------------------------------------------
module ofrs_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ofrs_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output ofrs_pkg::cmd_type pop_data
);

   import ofrs_pkg::*;

   localparam int PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type              entry_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full      = (count_ff == CNT_W'(CMDQ_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/ofrs_back.sv @@
// ----------------------------------------------------------------------------
// ofrs_back
// Sequencer: display mode, frame store, byte transfers and status results.
// ----------------------------------------------------------------------------
module ofrs_back #(
   parameter int FRAME_BYTES = ofrs_pkg::FRAME_BYTES_DEF,
   parameter int CHUNK_BYTES = ofrs_pkg::CHUNK_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ofrs_pkg::DEV_ADDR_W-1:0] device_address,
   input  logic [ofrs_pkg::DELAY_W-1:0]    startup_delay_ms,
   input  logic                            q_valid,
   input  ofrs_pkg::cmd_type               q_cmd,
   output logic                            q_pop,
   output logic                            sweep_busy,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ofrs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [ofrs_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);

   import ofrs_pkg::*;

   localparam int AW  = $clog2(FRAME_BYTES);
   localparam int FPW = $clog2(FRAME_BYTES + 1);
   localparam int CW  = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

   back_state_type    state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [DELAY_W-1:0] startup_count_ff, startup_count_in;
   logic [4:0]        init_pos_ff, init_pos_in;
   logic [2:0]        setup_pos_ff, setup_pos_in;
   logic [FPW-1:0]    frame_pos_ff, frame_pos_in;
   logic [CW-1:0]     chunk_idx_ff, chunk_idx_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic              clr_status_ff, clr_status_in;
   logic              is_frame_ff, is_frame_in;
   logic [7:0]        cmd_byte_ff, cmd_byte_in;
   logic              accepted_ff, accepted_in;
   logic [AW-1:0]     pix_addr_ff, pix_addr_in;
   logic [7:0]        pix_mask_ff, pix_mask_in;
   logic              pix_on_ff, pix_on_in;

   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_bvalid_ff, out_bvalid_in;
   logic              out_tstart_ff, out_tstart_in;
   logic              out_last_ff, out_last_in;
   logic              out_acc_ff, out_acc_in;
   logic              out_rdy_ff, out_rdy_in;
   logic              out_busy_ff, out_busy_in;
   logic              out_err_ff, out_err_in;

   logic              out_free;
   logic              emit;
   logic [7:0]        em_byte;
   logic              em_bvalid;
   logic              em_tstart;
   logic              em_last;
   logic [DELAY_W-1:0] count_inc;
   logic [FPW-1:0]    frame_pos_next;
   logic              chunk_end;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [7:0]        ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [7:0]        ram_rdata;

   ofrs_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES),
      .ADDR_W(AW)
   ) u_frame_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign out_free       = !out_valid_ff || rsp_tready;
   assign count_inc      = (q_cmd.ms && (startup_count_ff != '1))
                         ? startup_count_ff + 1'b1 : startup_count_ff;
   assign frame_pos_next = frame_pos_ff + 1'b1;
   assign chunk_end      = (chunk_idx_ff == CW'(CHUNK_BYTES - 1))
                        || (frame_pos_ff == FPW'(FRAME_BYTES - 1));
   assign sweep_busy     = (state_ff == BK_CLEAR) && !clr_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= BK_CLEAR;
         mode_ff          <= MODE_OFF;
         startup_count_ff <= '0;
         init_pos_ff      <= '0;
         setup_pos_ff     <= '0;
         frame_pos_ff     <= '0;
         chunk_idx_ff     <= '0;
         clr_addr_ff      <= '0;
         clr_status_ff    <= 1'b0;
         accepted_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         mode_ff          <= mode_in;
         startup_count_ff <= startup_count_in;
         init_pos_ff      <= init_pos_in;
         setup_pos_ff     <= setup_pos_in;
         frame_pos_ff     <= frame_pos_in;
         chunk_idx_ff     <= chunk_idx_in;
         clr_addr_ff      <= clr_addr_in;
         clr_status_ff    <= clr_status_in;
         accepted_ff      <= accepted_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_frame_ff   <= is_frame_in;
      cmd_byte_ff   <= cmd_byte_in;
      pix_addr_ff   <= pix_addr_in;
      pix_mask_ff   <= pix_mask_in;
      pix_on_ff     <= pix_on_in;
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_tstart_ff <= out_tstart_in;
      out_last_ff   <= out_last_in;
      out_acc_ff    <= out_acc_in;
      out_rdy_ff    <= out_rdy_in;
      out_busy_ff   <= out_busy_in;
      out_err_ff    <= out_err_in;
   end

   always_comb begin
      state_in         = state_ff;
      mode_in          = mode_ff;
      startup_count_in = startup_count_ff;
      init_pos_in      = init_pos_ff;
      setup_pos_in     = setup_pos_ff;
      frame_pos_in     = frame_pos_ff;
      chunk_idx_in     = chunk_idx_ff;
      clr_addr_in      = clr_addr_ff;
      clr_status_in    = clr_status_ff;
      is_frame_in      = is_frame_ff;
      cmd_byte_in      = cmd_byte_ff;
      accepted_in      = accepted_ff;
      pix_addr_in      = pix_addr_ff;
      pix_mask_in      = pix_mask_ff;
      pix_on_in        = pix_on_ff;
      q_pop            = 1'b0;
      emit             = 1'b0;
      em_byte          = '0;
      em_bvalid        = 1'b0;
      em_tstart        = 1'b0;
      em_last          = 1'b0;
      ram_we           = 1'b0;
      ram_waddr        = clr_addr_ff;
      ram_wdata        = '0;
      ram_re           = 1'b0;
      ram_raddr        = frame_pos_ff[AW-1:0];

      unique case (state_ff)
         BK_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(FRAME_BYTES - 1)) begin
               clr_addr_in = '0;
               state_in    = clr_status_ff ? BK_STATUS : BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               accepted_in = 1'b0;
               state_in    = BK_STATUS;
               unique case (q_cmd.kind)
                  CMD_STEP: begin
                     unique case (mode_ff)
                        MODE_WAIT: begin
                           startup_count_in = count_inc;
                           if (count_inc >= startup_delay_ms) begin
                              init_pos_in = '0;
                              mode_in     = MODE_INIT;
                           end
                        end
                        MODE_INIT: begin
                           if (init_pos_ff >= 5'(INIT_LEN)) begin
                              mode_in       = MODE_READY;
                              clr_addr_in   = '0;
                              clr_status_in = 1'b1;
                              state_in      = BK_CLEAR;
                           end else if (q_cmd.link_ready) begin
                              cmd_byte_in = INIT_LIST[init_pos_ff];
                              is_frame_in = 1'b0;
                              init_pos_in = init_pos_ff + 1'b1;
                              state_in    = BK_HDR_ADDR;
                           end
                        end
                        MODE_SETUP: begin
                           if (setup_pos_ff >= 3'(SETUP_LEN)) begin
                              frame_pos_in = '0;
                              mode_in      = MODE_FRAME;
                           end else if (q_cmd.link_ready) begin
                              cmd_byte_in  = WINDOW_LIST[setup_pos_ff];
                              is_frame_in  = 1'b0;
                              setup_pos_in = setup_pos_ff + 1'b1;
                              state_in     = BK_HDR_ADDR;
                           end
                        end
                        MODE_FRAME: begin
                           if (frame_pos_ff >= FPW'(FRAME_BYTES)) begin
                              mode_in = MODE_READY;
                           end else if (q_cmd.link_ready) begin
                              is_frame_in  = 1'b1;
                              chunk_idx_in = '0;
                              state_in     = BK_HDR_ADDR;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
                  CMD_PIXEL: begin
                     ram_re      = 1'b1;
                     ram_raddr   = q_cmd.pix_addr[AW-1:0];
                     pix_addr_in = q_cmd.pix_addr[AW-1:0];
                     pix_mask_in = q_cmd.pix_mask;
                     pix_on_in   = q_cmd.pix_on;
                     state_in    = BK_PX_WRITE;
                  end
                  CMD_CLEAR: begin
                     clr_addr_in   = '0;
                     clr_status_in = 1'b1;
                     state_in      = BK_CLEAR;
                  end
                  CMD_START: begin
                     startup_count_in = '0;
                     init_pos_in      = '0;
                     setup_pos_in     = '0;
                     frame_pos_in     = '0;
                     mode_in          = MODE_WAIT;
                     clr_addr_in      = '0;
                     clr_status_in    = 1'b1;
                     state_in         = BK_CLEAR;
                  end
                  CMD_UPDATE: begin
                     if (mode_ff == MODE_READY) begin
                        setup_pos_in = '0;
                        frame_pos_in = '0;
                        mode_in      = MODE_SETUP;
                        accepted_in  = 1'b1;
                     end
                  end
                  CMD_ERROR: begin
                     mode_in = MODE_ERROR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_PX_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = pix_addr_ff;
            ram_wdata = pix_on_ff ? (ram_rdata | pix_mask_ff) : (ram_rdata & ~pix_mask_ff);
            state_in  = BK_STATUS;
         end
         BK_HDR_ADDR: begin
            if (out_free) begin
               emit      = 1'b1;
               em_byte   = {device_address, 1'b0};
               em_bvalid = 1'b1;
               em_tstart = 1'b1;
               state_in  = BK_HDR_CTRL;
            end
         end
         BK_HDR_CTRL: begin
            if (out_free) begin
               emit      = 1'b1;
               em_byte   = is_frame_ff ? CTRL_DATA : CTRL_CMD;
               em_bvalid = 1'b1;
               if (is_frame_ff) begin
                  ram_re    = 1'b1;
                  ram_raddr = frame_pos_ff[AW-1:0];
                  state_in  = BK_FR_DATA;
               end else begin
                  state_in  = BK_CMD_BYTE;
               end
            end
         end
         BK_CMD_BYTE: begin
            if (out_free) begin
               emit      = 1'b1;
               em_byte   = cmd_byte_ff;
               em_bvalid = 1'b1;
               em_last   = 1'b1;
               state_in  = BK_IDLE;
            end
         end
         BK_FR_DATA: begin
            if (out_free) begin
               emit         = 1'b1;
               em_byte      = ram_rdata;
               em_bvalid    = 1'b1;
               em_last      = chunk_end;
               frame_pos_in = frame_pos_next;
               if (chunk_end) begin
                  state_in = BK_IDLE;
               end else begin
                  chunk_idx_in = chunk_idx_ff + 1'b1;
                  ram_re       = 1'b1;
                  ram_raddr    = frame_pos_next[AW-1:0];
               end
            end
         end
         BK_STATUS: begin
            if (out_free) begin
               emit     = 1'b1;
               em_last  = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in  = out_free ? emit : out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_tstart_in = out_tstart_ff;
      out_last_in   = out_last_ff;
      out_acc_in    = out_acc_ff;
      out_rdy_in    = out_rdy_ff;
      out_busy_in   = out_busy_ff;
      out_err_in    = out_err_ff;
      if (emit) begin
         out_byte_in   = em_byte;
         out_bvalid_in = em_bvalid;
         out_tstart_in = em_tstart;
         out_last_in   = em_last;
         out_acc_in    = accepted_ff;
         out_rdy_in    = (mode_ff == MODE_READY);
         out_busy_in   = (mode_ff == MODE_WAIT) || (mode_ff == MODE_INIT)
                      || (mode_ff == MODE_SETUP) || (mode_ff == MODE_FRAME);
         out_err_in    = (mode_ff == MODE_ERROR);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_err_ff, out_busy_ff, out_rdy_ff, out_acc_ff, out_byte_ff};
   assign rsp_tuser  = {out_tstart_ff, out_bvalid_ff};
   assign rsp_tlast  = out_last_ff;

   a_frame_pos_bound: assert property (@(posedge clock) disable iff (reset)
      frame_pos_ff <= FPW'(FRAME_BYTES))
      else $error("frame position beyond frame size");

   a_frame_data_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FR_DATA) |-> (mode_ff == MODE_FRAME) && is_frame_ff)
      else $error("frame data sent outside frame mode");

   a_cmd_byte_kind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CMD_BYTE) |-> !is_frame_ff && (mode_ff != MODE_FRAME))
      else $error("command byte during frame transfer");

   a_start_byte: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_tstart_ff) |-> out_bvalid_ff && !out_last_ff)
      else $error("transfer start on a non-byte or closing result");

   a_pixel_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_PX_WRITE) |-> $past(q_pop))
      else $error("pixel write without a popped command");

endmodule

@@ src/oled_framebuffer_refresh_sequencer_core.sv @@
// back end states: idle, status for a status result; idle, pixel write, status for a pixel
// write; idle, address, control, command byte for a command transfer; idle, address,
// control, data for a frame chunk (one frame store read a cycle unless rsp_tready stalls)
// clear, start and the end of the init list add a sweep of all FRAME_BYTES store addresses
// reset is synchronous; afterwards the frame store is swept to zero with req_tready low;
// csr writes are taken throughout
// ----------------------------------------------------------------------------
// oled_framebuffer_refresh_sequencer_core
// Monochrome oled frame store with init and page refresh transfer sequencer.
// ----------------------------------------------------------------------------
module oled_framebuffer_refresh_sequencer_core #(
   parameter int DISPLAY_WIDTH  = ofrs_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = ofrs_pkg::DISPLAY_HEIGHT_DEF,
   parameter int FRAME_BYTES    = ofrs_pkg::FRAME_BYTES_DEF,
   parameter int CHUNK_BYTES    = ofrs_pkg::CHUNK_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // millisecond_passed, link_ready, pixel_x[7:0], pixel_y[7:0], pixel_on, zero pad
   input  logic [ofrs_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[2:0]
   input  logic [ofrs_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tx_byte[7:0], request_accepted, is_ready, is_busy, is_error, zero pad
   output logic [ofrs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // byte_valid, transfer_start
   output logic [ofrs_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [ofrs_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [ofrs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import ofrs_pkg::*;

   logic [DEV_ADDR_W-1:0] device_address_ff, device_address_in;
   logic [DELAY_W-1:0]    startup_delay_ff, startup_delay_in;

   logic    q_push;
   cmd_type push_cmd;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   cmd_type pop_cmd;
   logic    sweep_busy;

   always_comb begin
      device_address_in = device_address_ff;
      startup_delay_in  = startup_delay_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_DEVICE_ADDRESS: device_address_in = csr_wdata[DEV_ADDR_W-1:0];
            CSR_STARTUP_DELAY:  startup_delay_in  = csr_wdata[DELAY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= DEV_ADDR_RESET;
         startup_delay_ff  <= DELAY_RESET;
      end else begin
         device_address_ff <= device_address_in;
         startup_delay_ff  <= startup_delay_in;
      end
   end

   ofrs_front #(
      .DISPLAY_WIDTH (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT(DISPLAY_HEIGHT),
      .FRAME_BYTES   (FRAME_BYTES)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .hold      (sweep_busy),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   ofrs_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_valid(q_valid),
      .pop_data (pop_cmd)
   );

   ofrs_back #(
      .FRAME_BYTES(FRAME_BYTES),
      .CHUNK_BYTES(CHUNK_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .device_address  (device_address_ff),
      .startup_delay_ms(startup_delay_ff),
      .q_valid         (q_valid),
      .q_cmd           (pop_cmd),
      .q_pop           (q_pop),
      .sweep_busy      (sweep_busy),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast)
   );

endmodule

@@ test/ofrs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofrs_checker
// Passive checker for the oled frame buffer refresh sequencer. It samples the
// request, response and csr ports at each rising edge. It keeps its own copy
// of the mode, the sequence positions and the page-organized frame store, and
// works out the response beats of every accepted request transaction. Each
// accepted response beat is compared field by field with the oldest beat due.
// ----------------------------------------------------------------------------
module ofrs_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [ofrs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [ofrs_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [ofrs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [ofrs_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [ofrs_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [ofrs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            drain_check,
   output int                              mismatches,
   output int                              pending,
   output int                              responses
);
   import ofrs_pkg::*;

   localparam int WIDTH        = DISPLAY_WIDTH_DEF;
   localparam int HEIGHT       = DISPLAY_HEIGHT_DEF;
   localparam int STORE_BYTES  = FRAME_BYTES_DEF;
   localparam int CHUNK        = CHUNK_BYTES_DEF;
   localparam int POWER_ON_LEN = 25;
   localparam int WINDOW_LEN   = 6;

   localparam logic [7:0] CTRL_COMMAND = 8'h00;
   localparam logic [7:0] CTRL_PIXELS  = 8'h40;
   localparam logic [9:0] COUNT_MAX    = 10'd1023;

   localparam logic [7:0] POWER_ON_CMDS [POWER_ON_LEN] = '{
      8'hAE, 8'hD5, 8'h80, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40, 8'h8D, 8'h14,
      8'h20, 8'h00, 8'hA1, 8'hC8, 8'hDA, 8'h12, 8'h81, 8'hCF, 8'hD9, 8'hF1,
      8'hDB, 8'h40, 8'hA4, 8'hA6, 8'hAF
   };

   localparam logic [7:0] WINDOW_CMDS [WINDOW_LEN] = '{
      8'h21, 8'h00, 8'h7F, 8'h22, 8'h00, 8'h07
   };

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] tx_byte;
      logic       transfer_start;
      logic       last;
      logic       accepted;
      logic       is_ready;
      logic       is_busy;
      logic       is_error;
   } beat_type;

   logic [6:0] dev_addr;
   logic [9:0] delay_ms;
   mode_type   mode;
   logic [9:0] ms_count;
   int         init_pos;
   int         setup_pos;
   int         frame_pos;
   logic [7:0] pixels [STORE_BYTES];
   logic [7:0] tx_burst [$];
   beat_type   beats_due [$];

   task automatic report(input string what, input int got, input int want);
      $display("mismatch on response %0d: %s is %0h, expected %0h", responses, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want) report(what, got, want);
   endtask

   task automatic wipe_pixels();
      foreach (pixels[i]) pixels[i] = 8'h00;
   endtask

   task automatic queue_command(input logic [7:0] cmd);
      tx_burst.push_back({dev_addr, 1'b0});
      tx_burst.push_back(CTRL_COMMAND);
      tx_burst.push_back(cmd);
   endtask

   task automatic predict_transaction(input logic [2:0] op, input logic ms,
         input logic link_ok, input logic [7:0] x, input logic [7:0] y, input logic on);
      int       idx;
      int       n;
      logic     taken;
      beat_type beat;
      taken = 1'b0;
      tx_burst.delete();
      case (op)
         OP_STEP: begin
            case (mode)
               MODE_WAIT: begin
                  if (ms && ms_count != COUNT_MAX) ms_count = ms_count + 10'd1;
                  if (ms_count >= delay_ms) begin
                     init_pos = 0;
                     mode = MODE_INIT;
                  end
               end
               MODE_INIT: begin
                  if (init_pos >= POWER_ON_LEN) begin
                     wipe_pixels();
                     mode = MODE_READY;
                  end else if (link_ok) begin
                     queue_command(POWER_ON_CMDS[init_pos]);
                     init_pos++;
                  end
               end
               MODE_SETUP: begin
                  if (setup_pos >= WINDOW_LEN) begin
                     frame_pos = 0;
                     mode = MODE_FRAME;
                  end else if (link_ok) begin
                     queue_command(WINDOW_CMDS[setup_pos]);
                     setup_pos++;
                  end
               end
               MODE_FRAME: begin
                  if (frame_pos >= STORE_BYTES) begin
                     mode = MODE_READY;
                  end else if (link_ok) begin
                     n = (STORE_BYTES - frame_pos > CHUNK) ? CHUNK : STORE_BYTES - frame_pos;
                     tx_burst.push_back({dev_addr, 1'b0});
                     tx_burst.push_back(CTRL_PIXELS);
                     for (int i = 0; i < n; i++) tx_burst.push_back(pixels[frame_pos + i]);
                     frame_pos += n;
                  end
               end
               default: ;
            endcase
         end
         OP_PIXEL: begin
            if (x < WIDTH && y < HEIGHT) begin
               idx = x + (y >> 3) * WIDTH;
               if (idx < STORE_BYTES) pixels[idx][y[2:0]] = on;
            end
         end
         OP_CLEAR: wipe_pixels();
         OP_START: begin
            wipe_pixels();
            ms_count = '0;
            init_pos = 0;
            setup_pos = 0;
            frame_pos = 0;
            mode = MODE_WAIT;
         end
         OP_UPDATE: begin
            if (mode == MODE_READY) begin
               setup_pos = 0;
               frame_pos = 0;
               mode = MODE_SETUP;
               taken = 1'b1;
            end
         end
         OP_ERROR: mode = MODE_ERROR;
         default: ;
      endcase

      n = (tx_burst.size() > 0) ? tx_burst.size() : 1;
      for (int k = 0; k < n; k++) begin
         beat.byte_valid     = tx_burst.size() > 0;
         beat.tx_byte        = (tx_burst.size() > 0) ? tx_burst[k] : 8'h00;
         beat.transfer_start = tx_burst.size() > 0 && k == 0;
         beat.last           = k == n - 1;
         beat.accepted       = taken;
         beat.is_ready       = mode == MODE_READY;
         beat.is_busy        = mode == MODE_WAIT || mode == MODE_INIT ||
                               mode == MODE_SETUP || mode == MODE_FRAME;
         beat.is_error       = mode == MODE_ERROR;
         beats_due.push_back(beat);
      end
   endtask

   always @(posedge clock) begin
      beat_type got;
      beat_type want;
      if (reset) begin
         dev_addr = DEV_ADDR_RESET;
         delay_ms = DELAY_RESET;
         mode = MODE_OFF;
         ms_count = '0;
         init_pos = 0;
         setup_pos = 0;
         frame_pos = 0;
         wipe_pixels();
         beats_due.delete();
         mismatches = 0;
         responses = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_DEVICE_ADDRESS: dev_addr = csr_wdata[DEV_ADDR_W-1:0];
               CSR_STARTUP_DELAY:  delay_ms = csr_wdata[DELAY_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.byte_valid     = rsp_tuser[0];
            got.transfer_start = rsp_tuser[1];
            got.tx_byte        = rsp_tdata[7:0];
            got.accepted       = rsp_tdata[8];
            got.is_ready       = rsp_tdata[9];
            got.is_busy        = rsp_tdata[10];
            got.is_error       = rsp_tdata[11];
            got.last           = rsp_tlast;
            if (beats_due.size() == 0) begin
               report("unexpected response, tdata", int'(rsp_tdata), 0);
            end else begin
               want = beats_due.pop_front();
               check_field("byte_valid", int'(got.byte_valid), int'(want.byte_valid));
               check_field("tx_byte", int'(got.tx_byte), int'(want.tx_byte));
               check_field("transfer_start", int'(got.transfer_start),
                           int'(want.transfer_start));
               check_field("last", int'(got.last), int'(want.last));
               check_field("request_accepted", int'(got.accepted), int'(want.accepted));
               check_field("is_ready", int'(got.is_ready), int'(want.is_ready));
               check_field("is_busy", int'(got.is_busy), int'(want.is_busy));
               check_field("is_error", int'(got.is_error), int'(want.is_error));
            end
            responses++;
         end
         if (req_tvalid && req_tready) begin
            predict_transaction(req_tuser, req_tdata[0], req_tdata[1], req_tdata[9:2],
                                req_tdata[17:10], req_tdata[18]);
         end
         if (drain_check && beats_due.size() != 0) begin
            report("responses never delivered, count", beats_due.size(), 0);
         end
      end
      pending <= beats_due.size();
   end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the oled frame buffer refresh sequencer. A short directed run
// covers pixel corners, ignored writes, refused updates, unused operations
// and the longest startup delay. Then four idling phases run power-up
// sequences and full frame refreshes with random link readiness, interleaved
// pixel writes and clears, broken sequences and random noise. The checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
   import ofrs_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int         TAIL_CYCLES = 2 * FRAME_BYTES_DEF + 100;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [REQ_USER_W-1:0] req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;
   logic                  drain_check = 1'b0;

   int mismatches;
   int pending;
   int responses;
   int idle_pct   = 0;
   int stall_pct  = 0;
   int items_sent = 0;
   int refreshes  = 0;
   int delay_now  = int'(DELAY_RESET);
   bit link_up    = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   oled_framebuffer_refresh_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   ofrs_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .drain_check (drain_check),
      .mismatches  (mismatches),
      .pending     (pending),
      .responses   (responses)
   );

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   task automatic send(input logic [2:0] op, input logic ms, input logic link_ok,
         input logic [7:0] x, input logic [7:0] y, input logic on);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, on, y, x, link_ok, ms};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic step(input logic ms, input logic link_ok);
      send(OP_STEP, ms, link_ok, 8'($urandom_range(255)), 8'($urandom_range(255)),
           1'($urandom_range(1)));
   endtask

   function automatic int WIDTH_MAX();
      return DISPLAY_WIDTH_DEF - 1;
   endfunction

   function automatic int HEIGHT_MAX();
      return DISPLAY_HEIGHT_DEF - 1;
   endfunction

   task automatic pixel();
      logic [7:0] x;
      logic [7:0] y;
      x = ($urandom_range(99) < 85) ? 8'($urandom_range(WIDTH_MAX())) : 8'($urandom_range(255));
      y = ($urandom_range(99) < 85) ? 8'($urandom_range(HEIGHT_MAX())) : 8'($urandom_range(255));
      send(OP_PIXEL, 1'($urandom_range(1)), 1'($urandom_range(1)), x, y, 1'($urandom_range(1)));
   endtask

   // hold off until every response due has been delivered
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      settle();
      repeat (40) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // rarely break the running sequence with an error or a restart
   task automatic sabotage();
      if ($urandom_range(1) == 0) send(OP_ERROR, 0, 0, 0, 0, 0);
      else send(OP_START, 0, 0, 0, 0, 0);
      link_up = 1'b0;
   endtask

   function automatic int POWER_ON_STEPS();
      return INIT_LEN;
   endfunction

   task automatic bring_up();
      int counted;
      int sent;
      int roll;
      logic ms;
      logic ok;
      link_up = 1'b0;
      send(OP_START, 1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)),
           8'($urandom_range(255)), 1'($urandom_range(1)));
      counted = 0;
      do begin
         roll = $urandom_range(99);
         if (roll < 1) begin
            sabotage();
            return;
         end else if (roll < 15) begin
            pixel();
         end else begin
            ms = ($urandom_range(99) < 80);
            step(ms, 1'($urandom_range(1)));
            if (ms && counted < 1023) counted++;
         end
      end while (counted < delay_now);
      sent = 0;
      while (sent <= POWER_ON_STEPS()) begin
         roll = $urandom_range(99);
         if (roll < 1) begin
            sabotage();
            return;
         end else if (roll < 15) begin
            pixel();
         end else begin
            ok = (sent == POWER_ON_STEPS()) ? 1'($urandom_range(1)) : ($urandom_range(99) < 85);
            step(1'($urandom_range(1)), ok);
            if (ok || sent == POWER_ON_STEPS()) sent++;
         end
      end
      link_up = 1'b1;
   endtask

   task automatic refresh();
      int goal;
      int sent;
      int roll;
      logic ok;
      send(OP_UPDATE, 1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)),
           8'($urandom_range(255)), 1'($urandom_range(1)));
      link_up = 1'b0;
      for (int stage = 0; stage < 2; stage++) begin
         goal = (stage == 0) ? SETUP_LEN : FRAME_BYTES_DEF / CHUNK_BYTES_DEF;
         sent = 0;
         while (sent <= goal) begin
            roll = $urandom_range(199);
            if (roll < 2) begin
               sabotage();
               return;
            end else if (roll < 6) begin
               send(OP_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (roll < 30) begin
               pixel();
            end else begin
               ok = (sent == goal) ? 1'($urandom_range(1)) : ($urandom_range(99) < 85);
               step(1'($urandom_range(1)), ok);
               if (ok || sent == goal) sent++;
            end
         end
      end
      link_up = 1'b1;
      refreshes++;
   endtask

   task automatic noise();
      int n;
      n = $urandom_range(3, 10);
      repeat (n) begin
         send(3'($urandom_range(7)), 1'($urandom_range(1)), 1'($urandom_range(1)),
              8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      link_up = 1'b0;
   endtask

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int roll;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // corners of the frame store, ignored writes and refused requests
      send(OP_PIXEL, 1, 1, 8'd0, 8'd0, 1);
      send(OP_PIXEL, 0, 0, 8'd127, 8'd63, 1);
      send(OP_PIXEL, 1, 0, 8'd128, 8'd0, 1);
      send(OP_PIXEL, 0, 1, 8'd0, 8'd64, 1);
      send(OP_PIXEL, 1, 1, 8'd255, 8'd255, 1);
      send(OP_PIXEL, 0, 0, 8'd127, 8'd63, 0);
      send(OP_UPDATE, 0, 0, 8'd0, 8'd0, 0);
      send(OP_SPARE_LO, 1, 1, 8'd255, 8'd255, 1);
      send(OP_SPARE_HI, 0, 0, 8'd0, 8'd0, 0);
      step(1, 1);
      send(OP_CLEAR, 0, 0, 8'd0, 8'd0, 0);
      send(OP_ERROR, 0, 0, 8'd0, 8'd0, 0);
      send(OP_START, 0, 0, 8'd0, 8'd0, 0);
      step(1, 1);
      step(0, 1);
      step(1, 0);
      send(OP_UPDATE, 0, 0, 8'd0, 8'd0, 0);
      send(OP_ERROR, 0, 0, 8'd0, 8'd0, 0);

      // longest startup delay, interrupted by a link error
      write_csr(CSR_STARTUP_DELAY, 1023);
      delay_now = 1023;
      send(OP_START, 0, 0, 8'd0, 8'd0, 0);
      repeat (4) step(1, 1);
      send(OP_ERROR, 0, 0, 8'd0, 8'd0, 0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
               write_csr(CSR_DEVICE_ADDRESS, 127);
               delay_now = 0;
            end
            1: begin
               idle_pct = 61;
               stall_pct = 0;
               write_csr(CSR_DEVICE_ADDRESS, 0);
               delay_now = 2;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 61;
               write_csr(CSR_DEVICE_ADDRESS, $urandom_range(127));
               delay_now = $urandom_range(4);
            end
            default: begin
               idle_pct = 21;
               stall_pct = 21;
               write_csr(CSR_DEVICE_ADDRESS, $urandom_range(127));
               delay_now = $urandom_range(6);
            end
         endcase
         write_csr(CSR_STARTUP_DELAY, delay_now);
         link_up = 1'b0;
         while (items_sent < 25 + 110 * (phase + 1)) begin
            roll = $urandom_range(99);
            if (link_up) begin
               if (roll < 75) refresh();
               else noise();
            end else begin
               if (roll < 85) bring_up();
               else noise();
            end
            if ($urandom_range(3) == 0) settle();
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      drain_check <= 1'b1;
      @(posedge clock);
      drain_check <= 1'b0;
      @(posedge clock);
      $display("covered %0d request and %0d response transactions, %0d full frame refreshes,",
               items_sent, responses, refreshes);
      $display("four idling phases, address and startup delay extremes, broken sequences");
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
